[rtl/frs_pkg.sv]
// ----------------------------------------------------------------------------
// frs_pkg
// Shared types and constants of the frame header resync unit.
// ----------------------------------------------------------------------------
package frs_pkg;

   localparam int unsigned HEADER_BYTES  = 4;
   localparam int unsigned QUEUE_DEPTH   = 8;
   localparam int unsigned LENGTH_W      = 12;
   localparam int unsigned SYNC_W        = 32;
   localparam int unsigned CSR_INDEX_W   = 1;
   localparam int unsigned PUSH_CNT_W    = 3;

   localparam logic [SYNC_W-1:0]   SYNC_RESET   = 32'hEFFE_0106;
   localparam logic [LENGTH_W-1:0] LENGTH_RESET = 12'd1032;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SYNC_WORD    = 1'b0,
      REG_FRAME_LENGTH = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_start;
      logic       frame_end;
      logic       step_last;
   } item_type;

   typedef struct packed {
      logic [PUSH_CNT_W-1:0]         count;
      item_type [HEADER_BYTES-1:0]   item;
   } push_type;

endpackage

[rtl/frs_if.sv]
// ----------------------------------------------------------------------------
// frs channel interfaces
// Valid/ready channels for raw bytes, frame bytes and register writes.
// ----------------------------------------------------------------------------
interface frs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface frs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       frame_start;
   logic       frame_end;
   logic       step_last;
   modport source (output valid, output out_byte, output frame_start,
                   output frame_end, output step_last, input ready);
   modport sink (input valid, input out_byte, input frame_start,
                 input frame_end, input step_last, output ready);
endinterface

interface frs_csr_if
   import frs_pkg::*;
;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [SYNC_W-1:0]      data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/frs_framer.sv]
// ----------------------------------------------------------------------------
// frs_framer
// Hunts for the sync word, tracks the frame position and produces the
// result beats caused by each accepted raw byte.
// ----------------------------------------------------------------------------
module frs_framer
   import frs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         room,
   frs_req_if.sink      req_bus,
   frs_csr_if.sink      csr_bus,
   output push_type     push
);

   logic [SYNC_W-1:0]   sync_ff, sync_in;
   logic [LENGTH_W-1:0] len_ff, len_in;
   logic [23:0]         win_ff, win_in;
   logic [1:0]          fill_ff, fill_in;
   logic                frame_ff, frame_in;
   logic [LENGTH_W-1:0] pos_ff, pos_in;

   logic                accept;
   logic [7:0]          b;
   logic [SYNC_W-1:0]   cand;
   logic [LENGTH_W-1:0] pos_next;
   logic                body_end;
   logic                short_frame;

   assign req_bus.ready = room;
   assign csr_bus.ready = 1'b1;
   assign accept        = req_bus.valid && room;
   assign b             = req_bus.data_byte;
   assign cand          = {win_ff, b};
   assign pos_next      = pos_ff + LENGTH_W'(1);
   assign body_end      = pos_next >= len_ff;
   assign short_frame   = len_ff <= LENGTH_W'(HEADER_BYTES);

   always_comb begin
      sync_in  = sync_ff;
      len_in   = len_ff;
      win_in   = win_ff;
      fill_in  = fill_ff;
      frame_in = frame_ff;
      pos_in   = pos_ff;
      push     = '0;
      if (csr_bus.valid) begin
         unique case (reg_index_type'(csr_bus.index))
            REG_SYNC_WORD:    sync_in = csr_bus.data;
            REG_FRAME_LENGTH: len_in  = csr_bus.data[LENGTH_W-1:0];
            default:          ;
         endcase
      end
      if (accept) begin
         if (frame_ff) begin
            push.count   = PUSH_CNT_W'(1);
            push.item[0] = '{out_byte: b, frame_start: 1'b0,
                             frame_end: body_end, step_last: 1'b1};
            pos_in = pos_next;
            if (body_end) begin
               frame_in = 1'b0;
               pos_in   = '0;
               win_in   = '0;
               fill_in  = '0;
            end
         end else if (fill_ff != 2'd3) begin
            win_in  = {win_ff[15:0], b};
            fill_in = fill_ff + 2'd1;
         end else if (cand != sync_ff) begin
            win_in = cand[23:0];
         end else begin
            push.count   = PUSH_CNT_W'(HEADER_BYTES);
            push.item[0] = '{out_byte: cand[31:24], frame_start: 1'b1,
                             frame_end: 1'b0, step_last: 1'b0};
            push.item[1] = '{out_byte: cand[23:16], frame_start: 1'b0,
                             frame_end: 1'b0, step_last: 1'b0};
            push.item[2] = '{out_byte: cand[15:8], frame_start: 1'b0,
                             frame_end: 1'b0, step_last: 1'b0};
            push.item[3] = '{out_byte: cand[7:0], frame_start: 1'b0,
                             frame_end: short_frame, step_last: 1'b1};
            win_in   = '0;
            fill_in  = '0;
            frame_in = !short_frame;
            pos_in   = short_frame ? '0 : LENGTH_W'(HEADER_BYTES);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff  <= SYNC_RESET;
         len_ff   <= LENGTH_RESET;
         win_ff   <= '0;
         fill_ff  <= '0;
         frame_ff <= 1'b0;
         pos_ff   <= '0;
      end else begin
         sync_ff  <= sync_in;
         len_ff   <= len_in;
         win_ff   <= win_in;
         fill_ff  <= fill_in;
         frame_ff <= frame_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

[rtl/frs_cell.sv]
// ----------------------------------------------------------------------------
// frs_cell
// One slot of the output queue: holds a beat, takes its neighbour's beat
// on a pop, or loads a freshly pushed beat.
// ----------------------------------------------------------------------------
module frs_cell
   import frs_pkg::*;
#(
   parameter int unsigned CntW = 4
) (
   input  logic            clock,
   input  logic [CntW-1:0] slot,
   input  logic [CntW-1:0] base,
   input  logic            pop,
   input  push_type        push,
   input  item_type        next_item,
   output item_type        item
);

   item_type        item_ff, item_in;
   logic [CntW-1:0] off;

   assign off  = slot - base;
   assign item = item_ff;

   always_comb begin
      item_in = item_ff;
      if (slot < base) begin
         if (pop) begin
            item_in = next_item;
         end
      end else if (off < CntW'(push.count)) begin
         item_in = push.item[off[1:0]];
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

[rtl/frame_header_resync_unit.sv]
// ----------------------------------------------------------------------------
// frame_header_resync_unit
// Realigns a raw byte stream on a sync word and forwards fixed-length frames
// through a row of queue cells.
//
//   channel   dir   payload                                     beat
//   req_bus   in    data_byte                                   raw byte
//   rsp_bus   out   out_byte, frame_start, frame_end, step_last frame byte
//   csr_bus   in    index, data                                 register write
//
// one raw byte per cycle while req ready; its beats enter the queue in the same cycle
// a sync match pushes four beats, a frame body byte one, a hunted byte none
// req ready while at most depth minus four beats are queued
// rsp beats leave from the registered head cell while rsp ready is high, one per cycle
// synchronous reset restores register defaults, clears framing state and queue count
// ----------------------------------------------------------------------------
module frame_header_resync_unit
   import frs_pkg::*;
#(
   parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   frs_req_if.sink  req_bus,
   frs_rsp_if.source rsp_bus,
   frs_csr_if.sink  csr_bus
);

   localparam int unsigned CntW = $clog2(QueueDepth + 1);

   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [CntW-1:0] base;
   logic            pop;
   logic            room;
   push_type        push;
   item_type        cells [QueueDepth];
   item_type        head;

   assign room = cnt_ff <= CntW'(QueueDepth - HEADER_BYTES);
   assign pop  = rsp_bus.valid && rsp_bus.ready;
   assign base = cnt_ff - CntW'(pop);
   assign cnt_in = base + CntW'(push.count);

   frs_framer u_framer (
      .clock   (clock),
      .reset   (reset),
      .room    (room),
      .req_bus (req_bus),
      .csr_bus (csr_bus),
      .push    (push)
   );

   for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
      item_type nb;
      if (i == QueueDepth - 1) begin : g_tail
         assign nb = '0;
      end else begin : g_body
         assign nb = cells[i+1];
      end
      frs_cell #(.CntW(CntW)) u_cell (
         .clock     (clock),
         .slot      (CntW'(i)),
         .base      (base),
         .pop       (pop),
         .push      (push),
         .next_item (nb),
         .item      (cells[i])
      );
   end

   assign head                = cells[0];
   assign rsp_bus.valid       = cnt_ff != '0;
   assign rsp_bus.out_byte    = head.out_byte;
   assign rsp_bus.frame_start = head.frame_start;
   assign rsp_bus.frame_end   = head.frame_end;
   assign rsp_bus.step_last   = head.step_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(QueueDepth))
      else $error("queue count beyond depth");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.frame_end |-> rsp_bus.step_last)
      else $error("frame end on a beat that is not the last of its byte");

   a_start_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.frame_start |-> !rsp_bus.step_last)
      else $error("frame start on the last beat of its byte");

   a_header_queued: assert property (@(posedge clock) disable iff (reset)
      push.count == PUSH_CNT_W'(HEADER_BYTES) |=> cnt_ff >= CntW'(HEADER_BYTES))
      else $error("header beats lost from queue");

endmodule
